FILE: rtl/pnghdr_pkg.sv
// Package with the constants, status codes and check functions of the PNG header checker.
package pnghdr_pkg;

  localparam int unsigned IdxW     = 5;
  localparam int unsigned HdrLen   = 29;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(HdrLen - 1);
  localparam logic [IdxW-1:0] ChunkIdx = IdxW'(8);
  localparam logic [IdxW-1:0] WidthIdx = IdxW'(16);
  localparam logic [IdxW-1:0] HeightIdx = IdxW'(20);
  localparam logic [IdxW-1:0] DepthIdx = IdxW'(24);
  localparam logic [IdxW-1:0] ColourIdx = IdxW'(25);
  localparam logic [IdxW-1:0] SigLastIdx = IdxW'(7);

  typedef enum logic [2:0] {
    StatusOk        = 3'd0,
    StatusSignature = 3'd1,
    StatusChunk     = 3'd2,
    StatusSize      = 3'd3,
    StatusDepth     = 3'd4,
    StatusColour    = 3'd5,
    StatusInterlace = 3'd6
  } status_e;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4E;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0D;
      3'd5: b = 8'h0A;
      3'd6: b = 8'h1A;
      3'd7: b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] chunk_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd3: b = 8'd13;
      3'd4: b = 8'h49;
      3'd5: b = 8'h48;
      3'd6: b = 8'h44;
      3'd7: b = 8'h52;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic status_e judge(input logic sig_ok, input status_e first_err,
                                    input logic [31:0] width, input logic [31:0] height,
                                    input logic [7:0] depth, input logic [7:0] colour,
                                    input logic [7:0] interlace);
    logic depth_ok;
    logic pair_ok;
    status_e s;
    depth_ok = (depth == 8'd1) || (depth == 8'd2) || (depth == 8'd4) ||
               (depth == 8'd8) || (depth == 8'd16);
    case (colour)
      8'd0: pair_ok = 1'b1;
      8'd3: pair_ok = (depth != 8'd16);
      8'd2, 8'd4, 8'd6: pair_ok = (depth >= 8'd8);
      default: pair_ok = 1'b0;
    endcase
    if (!sig_ok) begin
      s = StatusSignature;
    end else if (first_err != StatusOk) begin
      s = first_err;
    end else if ((width == 32'd0) || (height == 32'd0) || width[31] || height[31]) begin
      s = StatusSize;
    end else if (!depth_ok) begin
      s = StatusDepth;
    end else if (!pair_ok) begin
      s = StatusColour;
    end else if (interlace > 8'd1) begin
      s = StatusInterlace;
    end else begin
      s = StatusOk;
    end
    return s;
  endfunction

endpackage

FILE: rtl/png_header_checker.sv
// PNG header checker: signature, IHDR chunk and field checks on a byte stream.
// A result appears in the cycle after the byte that completes it is accepted (byte 29 or a last byte).
// Throughput: one byte per cycle; a byte that completes a result waits while an earlier result
// is held. The image-size product is computed by one registered
// 32x32 multiplier that settles while bytes 25 to 29 arrive.
// Reset: rst_ni clears the position and flags, so the first bytes start a new file.
module png_header_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_file_i,
  input  logic        last_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        signature_ok_o,
  output logic [31:0] image_width_o,
  output logic [31:0] image_height_o,
  output logic [7:0]  bit_depth_o,
  output logic [7:0]  colour_type_o,
  output logic [7:0]  interlace_method_o,
  output logic [63:0] rgba_bytes_o
);

  logic [pnghdr_pkg::IdxW-1:0] idx_q, idx_d, base_idx;
  logic given_q, given_d, base_given;
  pnghdr_pkg::status_e ferr_q, ferr_d, base_ferr;
  logic sig_q, sig_d, base_sig;
  logic [31:0] width_q, width_d, base_width;
  logic [31:0] height_q, height_d, base_height;
  logic [7:0] depth_q, depth_d, base_depth;
  logic [7:0] colour_q, colour_d, base_colour;
  logic [7:0] ilace_q, ilace_d, base_ilace;
  logic [63:0] product_q;
  logic emit, full, accept;
  pnghdr_pkg::status_e status;

  logic        out_valid_q;
  logic [2:0]  status_q;
  logic        sig_ok_q;
  logic [31:0] owidth_q, oheight_q;
  logic [7:0]  odepth_q, ocolour_q, oilace_q;
  logic [63:0] rgba_q;

  always_comb begin
    if (first_of_file_i) begin
      base_idx    = '0;
      base_given  = 1'b0;
      base_ferr   = pnghdr_pkg::StatusOk;
      base_sig    = 1'b1;
      base_width  = '0;
      base_height = '0;
      base_depth  = '0;
      base_colour = '0;
      base_ilace  = '0;
    end else begin
      base_idx    = idx_q;
      base_given  = given_q;
      base_ferr   = ferr_q;
      base_sig    = sig_q;
      base_width  = width_q;
      base_height = height_q;
      base_depth  = depth_q;
      base_colour = colour_q;
      base_ilace  = ilace_q;
    end
  end

  always_comb begin
    idx_d    = base_idx;
    given_d  = base_given;
    ferr_d   = base_ferr;
    sig_d    = base_sig;
    width_d  = base_width;
    height_d = base_height;
    depth_d  = base_depth;
    colour_d = base_colour;
    ilace_d  = base_ilace;
    full     = (base_idx == pnghdr_pkg::LastIdx);
    emit     = !base_given && (full || last_of_file_i);
    if (!base_given) begin
      if (base_idx < pnghdr_pkg::ChunkIdx) begin
        if (data_byte_i != pnghdr_pkg::sig_byte(base_idx[2:0])) begin
          sig_d = 1'b0;
        end
      end else if (base_idx < pnghdr_pkg::WidthIdx) begin
        if ((data_byte_i != pnghdr_pkg::chunk_byte(base_idx[2:0])) &&
            (base_ferr == pnghdr_pkg::StatusOk)) begin
          ferr_d = pnghdr_pkg::StatusChunk;
        end
      end else if (base_idx < pnghdr_pkg::HeightIdx) begin
        width_d = {base_width[23:0], data_byte_i};
      end else if (base_idx < pnghdr_pkg::DepthIdx) begin
        height_d = {base_height[23:0], data_byte_i};
      end else if (base_idx == pnghdr_pkg::DepthIdx) begin
        depth_d = data_byte_i;
      end else if (base_idx == pnghdr_pkg::ColourIdx) begin
        colour_d = data_byte_i;
      end else if (base_idx == pnghdr_pkg::LastIdx) begin
        ilace_d = data_byte_i;
      end
      if (emit) begin
        given_d = 1'b1;
      end else begin
        idx_d = base_idx + pnghdr_pkg::IdxW'(1);
      end
    end
    if (full) begin
      status = pnghdr_pkg::judge(sig_d, ferr_d, width_d, height_d, depth_d, colour_d, ilace_d);
    end else begin
      status = pnghdr_pkg::StatusSignature;
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i || !emit;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      given_q  <= 1'b0;
      ferr_q   <= pnghdr_pkg::StatusOk;
      sig_q    <= 1'b1;
      width_q  <= '0;
      height_q <= '0;
      depth_q  <= '0;
      colour_q <= '0;
      ilace_q  <= '0;
    end else if (accept) begin
      idx_q    <= idx_d;
      given_q  <= given_d;
      ferr_q   <= ferr_d;
      sig_q    <= sig_d;
      width_q  <= width_d;
      height_q <= height_d;
      depth_q  <= depth_d;
      colour_q <= colour_d;
      ilace_q  <= ilace_d;
    end
  end

  always_ff @(posedge clk_i) begin
    product_q <= 64'(width_q) * 64'(height_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      status_q  <= status;
      sig_ok_q  <= sig_d && (base_idx >= pnghdr_pkg::SigLastIdx);
      owidth_q  <= width_d;
      oheight_q <= height_d;
      odepth_q  <= depth_d;
      ocolour_q <= colour_d;
      oilace_q  <= ilace_d;
      rgba_q    <= (status == pnghdr_pkg::StatusOk) ? {product_q[61:0], 2'b00} : 64'd0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign signature_ok_o     = sig_ok_q;
  assign image_width_o      = owidth_q;
  assign image_height_o     = oheight_q;
  assign bit_depth_o        = odepth_q;
  assign colour_type_o      = ocolour_q;
  assign interlace_method_o = oilace_q;
  assign rgba_bytes_o       = rgba_q;

endmodule
